// ----- design/tos_pkg.sv -----
`default_nettype none

package tos_pkg;

  // Byte lanes per option word.
  localparam int unsigned Lanes = 4;

  // Option kinds.
  localparam logic [7:0] KindEol = 8'd0;
  localparam logic [7:0] KindNop = 8'd1;
  localparam logic [7:0] KindWs  = 8'd3;
  localparam logic [7:0] KindTs  = 8'd8;

  // Walk limits.
  localparam logic signed [7:0] TsMargin  = 8'sd10;
  localparam logic signed [7:0] WsMargin  = 8'sd3;
  localparam logic signed [7:0] AreaBase  = 8'sd20;
  localparam logic [7:0]        MinOptLen = 8'd2;
  localparam logic [7:0]        MaxShift  = 8'd14;
  localparam logic [5:0]        PosLimit  = 6'd60;
  localparam logic [5:0]        PosStep   = 6'd4;

  // Timestamp capture count: skip the length byte, then four value bytes.
  localparam logic [2:0] TsSkipLen = 3'd5;
  localparam logic [2:0] TsIdle    = 3'd0;

  // Window-scale capture countdown.
  localparam logic [1:0] WsWaitIdle = 2'd0;
  localparam logic [1:0] WsWaitTake = 2'd1;
  localparam logic [1:0] WsWaitSkip = 2'd2;

  // Walk and capture state carried from byte to byte.
  typedef struct packed {
    logic [2:0]  ts_count;     // timestamp bytes still to capture
    logic [31:0] ts_shift;     // timestamp capture register
    logic [1:0]  ws_wait;      // countdown to the window-scale shift byte
    logic [3:0]  ws_shift;     // clamped window-scale shift
    logic        stopped;      // walk has ended
    logic        len_pending;  // a length byte is awaited
    logic [8:0]  next_start;   // byte index of the next option start
    logic [1:0]  found;        // bit 0 timestamp, bit 1 window scale
  } scan_state_t;

  // One result item.
  typedef struct packed {
    logic        ts_found;
    logic [31:0] ts_value;
    logic        ws_found;
    logic [14:0] ws_factor;
  } result_t;

endpackage

`default_nettype wire

// ----- design/tos_opt_if.sv -----
`default_nettype none

interface tos_opt_if;
  logic        valid;
  logic        ready;
  logic [31:0] option_word;
  logic [3:0]  data_offset;
  logic        last;
  logic        empty_req;

  modport source (output valid, option_word, data_offset, last, empty_req, input ready);
  modport sink   (input valid, option_word, data_offset, last, empty_req, output ready);
endinterface

`default_nettype wire

// ----- design/tos_res_if.sv -----
`default_nettype none

interface tos_res_if;
  logic        valid;
  logic        ready;
  logic        ts_found;
  logic [31:0] ts_value;
  logic        ws_found;
  logic [14:0] ws_factor;

  modport source (output valid, ts_found, ts_value, ws_found, ws_factor, input ready);
  modport sink   (input valid, ts_found, ts_value, ws_found, ws_factor, output ready);
endinterface

`default_nettype wire

// ----- design/tos_lane.sv -----
`default_nettype none

// One byte of the option walk: advances the captures, then the kind/length walk.
module tos_lane (
  input  wire tos_pkg::scan_state_t st_cur,
  input  wire logic [7:0]           byte_val,
  input  wire logic [5:0]           pos,
  input  wire logic signed [7:0]    area,
  output tos_pkg::scan_state_t      st_new
);

  logic signed [7:0] pos_s;
  logic              at_len;
  logic              at_start;

  assign pos_s    = $signed({2'b00, pos});
  assign at_len   = ({4'b0000, pos} == ({1'b0, st_cur.next_start} + 10'd1));
  assign at_start = ({3'b000, pos} == st_cur.next_start);

  always_comb begin
    st_new = st_cur;

    // Timestamp capture: skip the length byte, then shift in value bytes.
    if (st_cur.ts_count == tos_pkg::TsSkipLen) begin
      st_new.ts_count = st_cur.ts_count - 3'd1;
    end else if (st_cur.ts_count != tos_pkg::TsIdle) begin
      st_new.ts_shift = {st_cur.ts_shift[23:0], byte_val};
      st_new.ts_count = st_cur.ts_count - 3'd1;
    end

    // Window-scale capture: the shift byte follows the length byte.
    if (st_cur.ws_wait == tos_pkg::WsWaitSkip) begin
      st_new.ws_wait = tos_pkg::WsWaitTake;
    end else if (st_cur.ws_wait == tos_pkg::WsWaitTake) begin
      st_new.ws_shift = (byte_val > tos_pkg::MaxShift) ? tos_pkg::MaxShift[3:0] : byte_val[3:0];
      st_new.ws_wait  = tos_pkg::WsWaitIdle;
    end

    // Kind/length walk.
    if (!st_cur.stopped) begin
      if (st_cur.len_pending) begin
        if (at_len) begin
          st_new.len_pending = 1'b0;
          if (byte_val < tos_pkg::MinOptLen) begin
            st_new.stopped = 1'b1;
          end else begin
            st_new.next_start = st_cur.next_start + {1'b0, byte_val};
          end
        end
      end else if (at_start) begin
        if ((pos_s + tos_pkg::WsMargin > area) || (byte_val == tos_pkg::KindEol)) begin
          st_new.stopped = 1'b1;
        end else if (byte_val == tos_pkg::KindNop) begin
          st_new.next_start = {3'b000, pos} + 9'd1;
        end else begin
          st_new.len_pending = 1'b1;
          if ((byte_val == tos_pkg::KindTs) && (pos_s + tos_pkg::TsMargin <= area)) begin
            st_new.found[0] = 1'b1;
            st_new.ts_count = tos_pkg::TsSkipLen;
          end
          if (byte_val == tos_pkg::KindWs) begin
            st_new.found[1] = 1'b1;
            st_new.ws_shift = 4'd0;
            st_new.ws_wait  = tos_pkg::WsWaitSkip;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/tos_merge.sv -----
`default_nettype none

// Builds the result from the state that the lanes leave at the end of a segment.
module tos_merge (
  input  wire tos_pkg::scan_state_t st_end,
  output tos_pkg::result_t          result
);

  logic [31:0] ts_final;

  // Value bytes that never arrived count as zero.
  always_comb begin
    unique case (st_end.ts_count)
      3'd0:    ts_final = st_end.ts_shift;
      3'd1:    ts_final = {st_end.ts_shift[23:0], 8'h00};
      3'd2:    ts_final = {st_end.ts_shift[15:0], 16'h0000};
      3'd3:    ts_final = {st_end.ts_shift[7:0], 24'h000000};
      default: ts_final = 32'h0000_0000;
    endcase
  end

  // Found flags gate both values.
  always_comb begin
    result.ts_found  = st_end.found[0];
    result.ts_value  = st_end.found[0] ? ts_final : 32'h0000_0000;
    result.ws_found  = st_end.found[1];
    result.ws_factor = st_end.found[1] ? (15'd1 << st_end.ws_shift) : 15'd1;
  end

endmodule

`default_nettype wire

// ----- design/tcp_option_scanner.sv -----
`default_nettype none

// TCP option scanner.
// The opt channel carries the option area of a segment, one 32-bit word per transfer,
// first byte in bits 31 to 24, with the header data offset. The word with last set
// closes the segment; a transfer with empty_req set closes it at once and its word is
// ignored. The res channel gives one transfer per segment: the timestamp and
// window-scale findings of a single kind/length walk over the area.
// Throughput is one word per cycle unless a result stalls. Four byte lanes, chained
// within the cycle, each take one byte of the word, so the lane chain sets the clock path.
// Latency: the result is presented in the cycle after the closing transfer.
// The result sits in an output register; while it waits to be taken, opt.ready is low,
// and it goes high again in the cycle the result is taken, so no word is lost.
// Reset (rst, synchronous) clears the walk state, the byte position and the output
// valid; the block accepts words in the first cycle after reset.
module tcp_option_scanner (
  input  wire logic  clk,
  input  wire logic  rst,
  tos_opt_if.sink    opt,
  tos_res_if.source  res
);

  tos_pkg::scan_state_t scan;
  tos_pkg::scan_state_t scan_next;
  logic [5:0]           byte_pos;
  logic [5:0]           byte_pos_next;
  tos_pkg::scan_state_t lane_st [tos_pkg::Lanes+1];
  tos_pkg::scan_state_t merge_in;
  tos_pkg::result_t     merge_out;
  tos_pkg::result_t     res_data;
  logic                 res_valid;
  logic                 accept;
  logic                 seg_end;
  logic signed [7:0]    area;

  // Handshake: take a word unless a result is waiting and stalled.
  assign opt.ready = !res_valid || res.ready;
  assign accept    = opt.valid && opt.ready;
  assign seg_end   = opt.empty_req || opt.last;

  // Option area length in bytes, negative for a short header.
  assign area = $signed({2'b00, opt.data_offset, 2'b00}) - tos_pkg::AreaBase;

  // Byte lanes, chained from the first byte on the wire.
  assign lane_st[0] = scan;
  for (genvar i = 0; i < tos_pkg::Lanes; i++) begin : g_lane
    tos_lane u_lane (
      .st_cur   (lane_st[i]),
      .byte_val (opt.option_word[8*(tos_pkg::Lanes-1-i) +: 8]),
      .pos      (byte_pos + 6'(i)),
      .area     (area),
      .st_new   (lane_st[i+1])
    );
  end

  // Merge: an empty request uses the state as it stands.
  assign merge_in = opt.empty_req ? scan : lane_st[tos_pkg::Lanes];

  tos_merge u_merge (
    .st_end (merge_in),
    .result (merge_out)
  );

  // Next walk state and byte position.
  always_comb begin
    scan_next     = scan;
    byte_pos_next = byte_pos;
    if (accept) begin
      if (seg_end) begin
        scan_next     = '0;
        byte_pos_next = 6'd0;
      end else begin
        scan_next     = lane_st[tos_pkg::Lanes];
        byte_pos_next = (byte_pos < tos_pkg::PosLimit) ? byte_pos + tos_pkg::PosStep
                                                       : tos_pkg::PosLimit;
      end
    end
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan     <= '0;
      byte_pos <= 6'd0;
    end else begin
      scan     <= scan_next;
      byte_pos <= byte_pos_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && seg_end) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && seg_end) begin
      res_data <= merge_out;
    end
  end

  assign res.valid     = res_valid;
  assign res.ts_found  = res_data.ts_found;
  assign res.ts_value  = res_data.ts_value;
  assign res.ws_found  = res_data.ws_found;
  assign res.ws_factor = res_data.ws_factor;

  // A stalled result blocks new words.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |-> !opt.ready)
    else $error("word accepted while a result is stalled");

  // Closing a segment presents a result and restarts the walk.
  a_close_result: assert property (@(posedge clk) disable iff (rst)
    (accept && seg_end) |=> (res_valid && (byte_pos == 6'd0) && (scan == '0)))
    else $error("segment close did not present a result and restart");

  // Timestamp capture runs only after an accepted timestamp option.
  a_ts_capture: assert property (@(posedge clk) disable iff (rst)
    !scan.found[0] |-> (scan.ts_count == tos_pkg::TsIdle))
    else $error("timestamp capture without an accepted option");

  // Window-scale capture runs only after an accepted window-scale option.
  a_ws_capture: assert property (@(posedge clk) disable iff (rst)
    !scan.found[1] |-> ((scan.ws_wait == tos_pkg::WsWaitIdle) && (scan.ws_shift == 4'd0)))
    else $error("window-scale capture without an accepted option");

  // Byte position moves in whole words and stops at its limit.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (byte_pos[1:0] == 2'b00) && (byte_pos <= tos_pkg::PosLimit))
    else $error("byte position out of range");

endmodule

`default_nettype wire
